>>> rtl/rtnp_pkg.sv
// rtnp_pkg: shared constants and controller/datapath command and status types
// for the ringtone text note parser. No dependencies.
package rtnp_pkg;

  // payload widths
  localparam int CHAR_W   = 8;
  localparam int SHIFT_W  = 2;
  localparam int INDEX_W  = 6;
  localparam int LENMS_W  = 19;

  // serial divider widths: dividend holds 4 * (60000 / tempo), divisor up to 1023
  localparam int DIVD_W   = 18;
  localparam int DIVS_W   = 10;

  // song defaults and timing constants
  localparam int unsigned MS_PER_MIN   = 60000;
  localparam int unsigned DEF_TEMPO    = 63;
  localparam int unsigned DEF_LENGTH   = 4;
  localparam int unsigned DEF_OCTAVE   = 6;
  localparam int unsigned SEMIS_PER_OCT = 12;
  localparam int unsigned BASE_OCTAVE  = 4;
  localparam int unsigned MAX_INDEX    = 61;

  // divider operand select
  typedef enum logic {
    DIV_SEL_TEMPO  = 1'b0,
    DIV_SEL_LENGTH = 1'b1
  } div_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic     step;      // input transaction taken this cycle
    logic     div_load;  // start a division
    div_sel_t div_sel;
    logic     push;      // load the output register
  } rtnp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic step_emit;     // current byte completes a note
    logic step_last;     // current byte is the final one
    logic div_busy;
  } rtnp_status_t;

endpackage

>>> rtl/rtnp_if.sv
// rtnp_if: valid/ready channel interfaces for text bytes and note results.
// Depends on rtnp_pkg.
interface rtnp_char_if import rtnp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] song_char;
  logic              last_char;

  modport source (output valid, output song_char, output last_char, input ready);
  modport sink   (input valid, input song_char, input last_char, output ready);
endinterface

interface rtnp_note_if import rtnp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] note_index;
  logic [LENMS_W-1:0] length_ms;
  logic               song_end;
  logic               note_valid;

  modport source (output valid, output note_index, output length_ms, output song_end,
                  output note_valid, input ready);
  modport sink   (input valid, input note_index, input length_ms, input song_end,
                  input note_valid, output ready);
endinterface

>>> rtl/rtnp_div.sv
// rtnp_div: restoring serial divider, one quotient bit per cycle.
// Depends on rtnp_pkg.
module rtnp_div import rtnp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              busy,
  output logic [DIVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] work;
  logic [DIVS_W-1:0] rem;
  logic [DIVS_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic [DIVS_W:0]   rem_sh;
  logic              fits;
  logic [DIVS_W:0]   rem_sub;

  // trial subtract of the shifted partial remainder
  assign rem_sh  = {rem, work[DIVD_W-1]};
  assign fits    = rem_sh >= {1'b0, dvs};
  assign rem_sub = rem_sh - {1'b0, dvs};

  // control: bit counter and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIVD_W);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // dividend shifts out while quotient bits shift in
  always_ff @(posedge clk) begin
    if (load) begin
      work <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      work <= {work[DIVD_W-2:0], fits};
      rem  <= fits ? rem_sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
    end
  end

  assign quotient = work;

endmodule

>>> rtl/rtnp_dp.sv
// rtnp_dp: text parser state, note operand snapshot, shared divider and
// output payload register. Depends on rtnp_pkg and rtnp_div.
module rtnp_dp import rtnp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  rtnp_cmd_t          cmd,
  output rtnp_status_t       status,
  input  logic [CHAR_W-1:0]  song_char,
  input  logic               last_char,
  input  logic               cfg_we,
  input  logic [SHIFT_W-1:0] cfg_wdata,
  output logic [INDEX_W-1:0] note_index,
  output logic [LENMS_W-1:0] length_ms,
  output logic               song_end,
  output logic               note_valid
);

  // ascii codes
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_O     = 8'h6F;

  localparam int FL_SHARP = 0;
  localparam int FL_DOT   = 1;
  localparam int FL_OCT   = 2;

  typedef enum logic [10:0] {
    PH_NAME     = 11'b000_0000_0001,
    PH_KEY      = 11'b000_0000_0010,
    PH_D_EQ     = 11'b000_0000_0100,
    PH_D_NUM    = 11'b000_0000_1000,
    PH_O_EQ     = 11'b000_0001_0000,
    PH_O_DIG    = 11'b000_0010_0000,
    PH_O_SEP    = 11'b000_0100_0000,
    PH_B_EQ     = 11'b000_1000_0000,
    PH_B_NUM    = 11'b001_0000_0000,
    PH_NOTE_LEN = 11'b010_0000_0000,
    PH_BODY     = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  dlen;
    logic [2:0]  doct;
    logic [9:0]  tempo;
    logic [9:0]  acc;
    logic [3:0]  pnote;
    logic [2:0]  pflags;
    logic [3:0]  poct;
  } pstate_t;

  localparam pstate_t PS_RESET = '{
    phase:  PH_NAME,
    dlen:   8'(DEF_LENGTH),
    doct:   3'(DEF_OCTAVE),
    tempo:  10'(DEF_TEMPO),
    acc:    '0,
    pnote:  '0,
    pflags: '0,
    poct:   '0
  };

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // decimal shift-in, saturating at 1023
  function automatic logic [9:0] acc_push(logic [9:0] acc, logic [7:0] c);
    logic [13:0] v;
    v = 14'({acc, 3'b000}) + 14'({acc, 1'b0}) + 14'(c[3:0]);
    return (v > 14'd1023) ? 10'd1023 : v[9:0];
  endfunction

  function automatic logic [3:0] letter_code(logic [7:0] c);
    logic [3:0] code;
    case (c)
      CH_C:    code = 4'd1;
      CH_D:    code = 4'd3;
      CH_E:    code = 4'd5;
      CH_F:    code = 4'd6;
      CH_G:    code = 4'd8;
      CH_A:    code = 4'd10;
      CH_B:    code = 4'd12;
      default: code = 4'd0;
    endcase
    return code;
  endfunction

  // length digits, else the note letter opens the note body
  function automatic pstate_t feed_len(pstate_t s, logic [7:0] c);
    pstate_t r;
    r = s;
    if (is_digit(c)) begin
      r.acc = acc_push(s.acc, c);
    end else begin
      r.pnote  = letter_code(c);
      r.pflags = '0;
      r.poct   = '0;
      r.phase  = PH_BODY;
    end
    return r;
  endfunction

  logic [SHIFT_W-1:0] octave_shift;
  pstate_t            ps;
  pstate_t            nx;
  pstate_t            fin;
  logic               emit_body;
  logic               emit;
  logic [9:0]         fin_tempo;
  logic [9:0]         fin_div;
  logic [3:0]         fin_oct;
  logic [4:0]         oct_sum;
  logic [7:0]         idx_raw;
  logic [7:0]         idx_off;
  logic [INDEX_W-1:0] fin_idx;

  logic               res_emit;
  logic               res_last;
  logic               res_dot;
  logic [INDEX_W-1:0] res_idx;
  logic [9:0]         res_tempo;
  logic [9:0]         res_div;

  logic               div_busy;
  logic [DIVD_W-1:0]  quot;
  logic [DIVD_W-1:0]  div_dividend;
  logic [DIVS_W-1:0]  div_divisor;
  logic [LENMS_W-1:0] dur;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      octave_shift <= '0;
    end else if (cfg_we) begin
      octave_shift <= cfg_wdata;
    end
  end

  // one parse step for the incoming byte
  always_comb begin
    nx        = ps;
    emit_body = 1'b0;
    unique case (ps.phase)
      PH_NAME: begin
        if (song_char == CH_COLON) nx.phase = PH_KEY;
      end
      PH_KEY: begin
        nx.acc = '0;
        if (song_char == CH_D) begin
          nx.phase = PH_D_EQ;
        end else if (song_char == CH_O) begin
          nx.phase = PH_O_EQ;
        end else if (song_char == CH_B) begin
          nx.phase = PH_B_EQ;
        end else if (song_char == CH_COLON) begin
          nx.phase = PH_NOTE_LEN;
        end else begin
          nx.phase = PH_NOTE_LEN;
          nx = feed_len(nx, song_char);
        end
      end
      PH_D_EQ: begin
        nx.acc   = '0;
        nx.phase = PH_D_NUM;
      end
      PH_D_NUM: begin
        if (is_digit(song_char)) begin
          nx.acc = acc_push(ps.acc, song_char);
        end else begin
          if (ps.acc != '0) begin
            nx.dlen = (ps.acc > 10'd255) ? 8'd255 : ps.acc[7:0];
          end
          nx.acc   = '0;
          nx.phase = (song_char == CH_COLON) ? PH_NOTE_LEN : PH_KEY;
        end
      end
      PH_O_EQ: begin
        nx.phase = PH_O_DIG;
      end
      PH_O_DIG: begin
        if ((song_char >= CH_THREE) && (song_char <= CH_SEVEN)) begin
          nx.doct = song_char[2:0];
        end
        nx.phase = PH_O_SEP;
      end
      PH_O_SEP: begin
        nx.acc   = '0;
        nx.phase = (song_char == CH_COLON) ? PH_NOTE_LEN : PH_KEY;
      end
      PH_B_EQ: begin
        nx.acc   = '0;
        nx.phase = PH_B_NUM;
      end
      PH_B_NUM: begin
        if (is_digit(song_char)) begin
          nx.acc = acc_push(ps.acc, song_char);
        end else begin
          nx.tempo = (ps.acc != '0) ? ps.acc : 10'(DEF_TEMPO);
          nx.acc   = '0;
          nx.phase = (song_char == CH_COLON) ? PH_NOTE_LEN : PH_KEY;
        end
      end
      PH_NOTE_LEN: begin
        nx = feed_len(ps, song_char);
      end
      PH_BODY: begin
        if ((song_char == CH_HASH) && (ps.pflags == '0)) begin
          nx.pflags[FL_SHARP] = 1'b1;
          nx.pnote            = ps.pnote + 4'd1;
        end else if ((song_char == CH_DOT) && !ps.pflags[FL_DOT] && !ps.pflags[FL_OCT]) begin
          nx.pflags[FL_DOT] = 1'b1;
        end else if (is_digit(song_char) && !ps.pflags[FL_OCT]) begin
          nx.pflags[FL_OCT] = 1'b1;
          nx.poct           = song_char[3:0];
        end else begin
          // byte ends the note; anything but a comma starts the next one
          emit_body = 1'b1;
          nx.acc    = '0;
          nx.phase  = PH_NOTE_LEN;
          if (song_char != CH_COMMA) begin
            nx = feed_len(nx, song_char);
          end
        end
      end
      default: begin
        nx.phase = PH_NAME;
      end
    endcase
  end

  // note completion: by a terminator, or by the final byte inside a note body
  assign emit = emit_body || (last_char && (nx.phase == PH_BODY));
  assign fin  = emit_body ? ps : nx;

  // operands of the finished note
  assign fin_tempo = (fin.tempo != '0) ? fin.tempo : 10'(DEF_TEMPO);
  assign fin_div   = (fin.acc != '0) ? fin.acc : {2'b00, fin.dlen};
  assign fin_oct   = fin.pflags[FL_OCT] ? fin.poct : {1'b0, fin.doct};
  assign oct_sum   = {1'b0, fin_oct} + {3'b000, octave_shift};
  assign idx_raw   = 8'({oct_sum, 3'b000}) + 8'({oct_sum, 2'b00}) + {4'b0000, fin.pnote};
  assign idx_off   = idx_raw - 8'(BASE_OCTAVE * SEMIS_PER_OCT);

  // semitone index, clamped to the table range
  always_comb begin
    if (fin.pnote == '0) begin
      fin_idx = '0;
    end else if (idx_raw <= 8'(BASE_OCTAVE * SEMIS_PER_OCT)) begin
      fin_idx = '0;
    end else if (idx_off > 8'(MAX_INDEX)) begin
      fin_idx = INDEX_W'(MAX_INDEX);
    end else begin
      fin_idx = idx_off[INDEX_W-1:0];
    end
  end

  // parser state, restarted after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      ps <= PS_RESET;
    end else if (cmd.step) begin
      ps <= last_char ? PS_RESET : nx;
    end
  end

  // note snapshot for the divisions and the result
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      res_emit  <= emit;
      res_last  <= last_char;
      res_dot   <= fin.pflags[FL_DOT];
      res_idx   <= fin_idx;
      res_tempo <= fin_tempo;
      res_div   <= fin_div;
    end
  end

  // first pass 60000 / tempo, second pass 4 * that / length
  always_comb begin
    unique case (cmd.div_sel)
      DIV_SEL_TEMPO: begin
        div_dividend = DIVD_W'(MS_PER_MIN);
        div_divisor  = res_tempo;
      end
      DIV_SEL_LENGTH: begin
        div_dividend = {quot[DIVD_W-3:0], 2'b00};
        div_divisor  = res_div;
      end
      default: begin
        div_dividend = DIVD_W'(MS_PER_MIN);
        div_divisor  = res_tempo;
      end
    endcase
  end

  rtnp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (cmd.div_load),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (quot)
  );

  // dotted notes last half again as long
  assign dur = res_dot ? ({1'b0, quot} + {2'b00, quot[DIVD_W-1:1]}) : {1'b0, quot};

  // output payload register
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      note_index <= res_emit ? res_idx : '0;
      length_ms  <= res_emit ? dur : '0;
      note_valid <= res_emit;
      song_end   <= res_last;
    end
  end

  assign status.step_emit = emit;
  assign status.step_last = last_char;
  assign status.div_busy  = div_busy;

endmodule

>>> rtl/rtnp_ctrl.sv
// rtnp_ctrl: sequencing state machine for input, the two divisions and the
// output register valid flag. Depends on rtnp_pkg.
module rtnp_ctrl import rtnp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  rtnp_status_t status,
  output rtnp_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LOAD_T = 6'b000010,
    S_RUN_T  = 6'b000100,
    S_LOAD_L = 6'b001000,
    S_RUN_L  = 6'b010000,
    S_PUSH   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (status.step_emit) begin
            state_next = S_LOAD_T;
          end else if (status.step_last) begin
            state_next = S_PUSH;
          end
        end
      end
      S_LOAD_T: state_next = S_RUN_T;
      S_RUN_T: begin
        if (!status.div_busy) state_next = S_LOAD_L;
      end
      S_LOAD_L: state_next = S_RUN_L;
      S_RUN_L: begin
        if (!status.div_busy) state_next = S_PUSH;
      end
      S_PUSH: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // commands
  assign cmd.step     = accept;
  assign cmd.div_load = (state == S_LOAD_T) || (state == S_LOAD_L);
  assign cmd.div_sel  = (state == S_LOAD_L) ? DIV_SEL_LENGTH : DIV_SEL_TEMPO;
  assign cmd.push     = (state == S_PUSH) && slot_free;

  // output register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> rtl/ringtone_text_note_parser_top.sv
// ringtone text note parser, top level. A byte that completes a note has its
// result in the output register after two serial divisions in one shared
// divider and the push; no further byte is taken until the push is done.
// Other bytes do not pause intake; a final byte with no note goes straight to the push.
// A result still waiting in the output register holds off the push. Synchronous
// active-high reset restarts the parser, clears the octave shift and empties the output.
module ringtone_text_note_parser_top import rtnp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  rtnp_char_if.sink          song_in,
  rtnp_note_if.source        note_out,
  input  logic               cfg_we,
  input  logic [SHIFT_W-1:0] cfg_wdata
);

  rtnp_cmd_t    cmd;
  rtnp_status_t status;

  rtnp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (song_in.valid),
    .in_ready  (song_in.ready),
    .out_valid (note_out.valid),
    .out_ready (note_out.ready),
    .status    (status),
    .cmd       (cmd)
  );

  rtnp_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .song_char  (song_in.song_char),
    .last_char  (song_in.last_char),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .note_index (note_out.note_index),
    .length_ms  (note_out.length_ms),
    .song_end   (note_out.song_end),
    .note_valid (note_out.note_valid)
  );

endmodule

>>> rtl/rtnp_checker.sv
// rtnp_checker: port-level assertions for the parser top, bound to it below.
// Depends on rtnp_pkg.
module rtnp_checker import rtnp_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_last,
  input logic               out_valid,
  input logic               out_ready,
  input logic [INDEX_W-1:0] note_index,
  input logic [LENMS_W-1:0] length_ms,
  input logic               song_end,
  input logic               note_valid
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(note_index) && $stable(length_ms)
      && $stable(song_end) && $stable(note_valid))
    else $error("stalled result changed");

  // the final byte always produces a result, so intake pauses
  a_last_pause: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken right after final byte");

  // an empty result carries zeros
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !note_valid |-> (note_index == '0) && (length_ms == '0))
    else $error("empty result with nonzero payload");

  // only the end-of-song result may lack a note
  a_end_only_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !song_end |-> note_valid)
    else $error("empty result without song end");

  // index stays within the table
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> note_index <= INDEX_W'(MAX_INDEX))
    else $error("note index out of range");

endmodule

bind ringtone_text_note_parser_top rtnp_checker u_rtnp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (song_in.valid),
  .in_ready   (song_in.ready),
  .in_last    (song_in.last_char),
  .out_valid  (note_out.valid),
  .out_ready  (note_out.ready),
  .note_index (note_out.note_index),
  .length_ms  (note_out.length_ms),
  .song_end   (note_out.song_end),
  .note_valid (note_out.note_valid)
);
